/* rtl/tres_pkg.sv */
package tres_pkg;

   localparam int COORD_W = 16;
   localparam int DWELL_W = 20;
   localparam int PERIOD_W = 16;
   localparam int DIM_W = 12;
   localparam int POS_W = 11;
   localparam int LEN_W = 12;
   localparam int CSR_IDX_W = 3;

   localparam logic [DIM_W-1:0] MAX_SURFACE_DIM = 12'd2048;

   localparam logic CMD_ERASE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DWELL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SURF_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SURF_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SURF_LIVE = 3'd4;

   typedef struct packed {
      logic command;
      logic signed [COORD_W-1:0] rect_x;
      logic signed [COORD_W-1:0] rect_y;
      logic signed [COORD_W-1:0] rect_w;
      logic signed [COORD_W-1:0] rect_h;
      logic [DWELL_W-1:0] dwell_ms;
      logic panic;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] erase_x;
      logic [POS_W-1:0] erase_y;
      logic [LEN_W-1:0] erase_w;
      logic [LEN_W-1:0] erase_h;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [DWELL_W-1:0] reg_data;
   } csr_type;

   typedef struct packed {
      logic used;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] w;
      logic signed [COORD_W-1:0] h;
      logic [DWELL_W-1:0] remaining_ms;
   } slot_type;

   typedef struct packed {
      logic ok;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [LEN_W-1:0] w;
      logic [LEN_W-1:0] h;
   } clip_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

/* rtl/tres_chan_if.sv */
interface tres_chan_if #(
   parameter type payload_type = logic
) ();
   logic valid;
   logic ready;
   payload_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

/* rtl/tres_cell.sv */
module tres_cell (
   input logic clock,
   input logic reset,
   input logic shift_en,
   input tres_pkg::slot_type shift_in,
   input logic load_en,
   input tres_pkg::slot_type load_data,
   input logic clear_en,
   output tres_pkg::slot_type slot_out
);
   import tres_pkg::*;

   logic used_ff;
   slot_type data_ff;

   // Only the used flag is control state; the payload is valid only while used.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (clear_en) begin
         used_ff <= 1'b0;
      end else if (load_en) begin
         used_ff <= 1'b1;
      end else if (shift_en) begin
         used_ff <= shift_in.used;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         data_ff <= load_data;
      end else if (shift_en) begin
         data_ff <= shift_in;
      end
   end

   always_comb begin
      slot_out = data_ff;
      slot_out.used = used_ff;
   end

endmodule

/* rtl/tres_clip.sv */
module tres_clip (
   input logic live,
   input logic [tres_pkg::DIM_W-1:0] surf_w,
   input logic [tres_pkg::DIM_W-1:0] surf_h,
   input logic signed [tres_pkg::COORD_W-1:0] x,
   input logic signed [tres_pkg::COORD_W-1:0] y,
   input logic signed [tres_pkg::COORD_W-1:0] w,
   input logic signed [tres_pkg::COORD_W-1:0] h,
   output tres_pkg::clip_type result
);
   import tres_pkg::*;

   localparam int CW = COORD_W + 2;

   logic signed [CW-1:0] x0, y0, w0, h0;
   logic signed [CW-1:0] x1, y1, w1, h1;
   logic signed [CW-1:0] w2, h2;
   logic signed [CW-1:0] sw, sh;

   always_comb begin
      x0 = {{2{x[COORD_W-1]}}, x};
      y0 = {{2{y[COORD_W-1]}}, y};
      w0 = {{2{w[COORD_W-1]}}, w};
      h0 = {{2{h[COORD_W-1]}}, h};
      sw = {{(CW-DIM_W){1'b0}}, surf_w};
      sh = {{(CW-DIM_W){1'b0}}, surf_h};

      // A negative corner eats into the size and is pulled to the edge.
      w1 = (x0 < 0) ? w0 + x0 : w0;
      x1 = (x0 < 0) ? '0 : x0;
      h1 = (y0 < 0) ? h0 + y0 : h0;
      y1 = (y0 < 0) ? '0 : y0;

      w2 = (x1 + w1 > sw) ? sw - x1 : w1;
      h2 = (y1 + h1 > sh) ? sh - y1 : h1;

      result.ok = live && (w0 > 0) && (h0 > 0) && (x1 < sw) && (y1 < sh)
                  && (w2 > 0) && (h2 > 0);
      result.x = x1[POS_W-1:0];
      result.y = y1[POS_W-1:0];
      result.w = w2[LEN_W-1:0];
      result.h = h2[LEN_W-1:0];
   end

endmodule

/* rtl/timed_rect_erase_scheduler.sv */
// Timed rectangle erase scheduler. Erase requests with a nonzero dwell are
// parked in one of PENDING_SLOTS pending slots (lowest free slot first, dwell
// clamped to max_dwell_ms); a request with zero dwell, or one that finds every
// slot taken, is erased at once. Each tick request stands for tick_period_ms
// of time: the slots are held in a ring of cells that rotates once around
// during the tick, so slot 0 is looked at first, and each slot either loses a
// period or expires and is emitted. A tick with panic frees every slot and
// emits one whole-surface erase. Every emitted rectangle is clipped to the
// surface and dropped if the clip is empty; nothing is emitted while
// surface_live is 0, and a tick then changes nothing. The last response
// caused by one request carries last = 1. A tick request that scans the slots
// passes through the decode, scan and finish states, the ring rotating one
// cell per cycle while the response register is free or being taken. A panic
// tick or an immediate erase goes from decode to finish; a tick on a dead
// surface and a stored erase request return to idle from decode. The finish
// step also waits while the response register is full and not taken.
// Configuration writes are always accepted and must be made while idle.
module timed_rect_erase_scheduler #(
   parameter int PENDING_SLOTS = 8
) (
   input logic clock,
   input logic reset,
   tres_chan_if.sink req_chan,
   tres_chan_if.source rsp_chan,
   tres_chan_if.sink csr_chan
);
   import tres_pkg::*;

   localparam int IDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PENDING_SLOTS - 1);

   // Configuration registers.
   logic [DWELL_W-1:0] max_dwell_ff;
   logic [PERIOD_W-1:0] tick_period_ff;
   logic [DIM_W-1:0] surf_width_ff;
   logic [DIM_W-1:0] surf_height_ff;
   logic surf_live_ff;

   // Sequencer and datapath registers.
   state_type state_ff, state_in;
   req_type item_ff;
   logic [IDX_W-1:0] scan_cnt_ff;
   logic hold_valid_ff;
   clip_type hold_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   // Control decoded from the state.
   logic req_ready;
   logic store_en;
   logic clear_en;
   logic shift_en;
   logic hold_load;
   logic out_load;
   logic out_last;
   logic out_free;

   slot_type cell_q [PENDING_SLOTS];
   slot_type head_next;
   slot_type new_slot;
   logic expire;
   logic [IDX_W-1:0] free_idx;
   logic any_free;
   logic [DWELL_W-1:0] clamped_ms;
   logic [DIM_W-1:0] surf_w_eff;
   logic [DIM_W-1:0] surf_h_eff;
   logic signed [COORD_W-1:0] clip_x, clip_y, clip_w, clip_h;
   clip_type clip_res;
   logic accept;

   assign accept = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dwell_ff <= 20'd10000;
         tick_period_ff <= 16'd150;
         surf_width_ff <= 12'd800;
         surf_height_ff <= 12'd480;
         surf_live_ff <= 1'b1;
      end else if (csr_chan.valid) begin
         case (csr_chan.data.reg_index)
            CSR_MAX_DWELL: max_dwell_ff <= csr_chan.data.reg_data;
            CSR_TICK_PERIOD: tick_period_ff <= csr_chan.data.reg_data[PERIOD_W-1:0];
            CSR_SURF_WIDTH: surf_width_ff <= csr_chan.data.reg_data[DIM_W-1:0];
            CSR_SURF_HEIGHT: surf_height_ff <= csr_chan.data.reg_data[DIM_W-1:0];
            CSR_SURF_LIVE: surf_live_ff <= csr_chan.data.reg_data[0];
            default: ;
         endcase
      end
   end

   // Sizes beyond the largest supported surface saturate for clipping.
   assign surf_w_eff = (surf_width_ff > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : surf_width_ff;
   assign surf_h_eff = (surf_height_ff > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : surf_height_ff;

   // Lowest free slot for a request that gets parked.
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
         if (!cell_q[i].used) begin
            free_idx = IDX_W'(i);
            any_free = 1'b1;
         end
      end
   end

   assign clamped_ms = (item_ff.dwell_ms > max_dwell_ff) ? max_dwell_ff : item_ff.dwell_ms;

   always_comb begin
      new_slot.used = 1'b1;
      new_slot.x = item_ff.rect_x;
      new_slot.y = item_ff.rect_y;
      new_slot.w = item_ff.rect_w;
      new_slot.h = item_ff.rect_h;
      new_slot.remaining_ms = clamped_ms;
   end

   // The head cell is the slot under inspection; after processing it goes
   // to the tail, so one full rotation brings every slot back to its place.
   assign expire = cell_q[0].used
                   && !(cell_q[0].remaining_ms > {{(DWELL_W-PERIOD_W){1'b0}}, tick_period_ff});

   always_comb begin
      head_next = cell_q[0];
      head_next.used = cell_q[0].used && !expire;
      head_next.remaining_ms = cell_q[0].remaining_ms
                               - {{(DWELL_W-PERIOD_W){1'b0}}, tick_period_ff};
   end

   for (genvar k = 0; k < PENDING_SLOTS; k++) begin : g_cell
      slot_type shift_src;
      if (k == PENDING_SLOTS - 1) begin : g_tail
         assign shift_src = head_next;
      end else begin : g_mid
         assign shift_src = cell_q[k+1];
      end
      tres_cell u_cell (
         .clock(clock),
         .reset(reset),
         .shift_en(shift_en),
         .shift_in(shift_src),
         .load_en(store_en && (free_idx == IDX_W'(k))),
         .load_data(new_slot),
         .clear_en(clear_en),
         .slot_out(cell_q[k])
      );
   end

   // The clip unit sees the request itself, the whole surface on a panic,
   // or the head slot during the rotation.
   always_comb begin
      if (state_ff == ST_DECODE && item_ff.command == CMD_ERASE) begin
         clip_x = item_ff.rect_x;
         clip_y = item_ff.rect_y;
         clip_w = item_ff.rect_w;
         clip_h = item_ff.rect_h;
      end else if (state_ff == ST_DECODE) begin
         clip_x = '0;
         clip_y = '0;
         clip_w = {{(COORD_W-DIM_W){1'b0}}, surf_w_eff};
         clip_h = {{(COORD_W-DIM_W){1'b0}}, surf_h_eff};
      end else begin
         clip_x = cell_q[0].x;
         clip_y = cell_q[0].y;
         clip_w = cell_q[0].w;
         clip_h = cell_q[0].h;
      end
   end

   tres_clip u_clip (
      .live(surf_live_ff),
      .surf_w(surf_w_eff),
      .surf_h(surf_h_eff),
      .x(clip_x),
      .y(clip_y),
      .w(clip_w),
      .h(clip_h),
      .result(clip_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (item_ff.command == CMD_ERASE) begin
               if (item_ff.dwell_ms != '0 && any_free) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (!surf_live_ff) begin
               state_in = ST_IDLE;
            end else if (item_ff.panic) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free && scan_cnt_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer. A found erase waits in the hold register until
   // the next one shows up or the request ends, which tells whether it is last.
   always_comb begin
      req_ready = 1'b0;
      store_en = 1'b0;
      clear_en = 1'b0;
      shift_en = 1'b0;
      hold_load = 1'b0;
      out_load = 1'b0;
      out_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_DECODE: begin
            if (item_ff.command == CMD_ERASE) begin
               if (item_ff.dwell_ms != '0 && any_free) begin
                  store_en = 1'b1;
               end else begin
                  hold_load = clip_res.ok;
               end
            end else if (surf_live_ff && item_ff.panic) begin
               clear_en = 1'b1;
               hold_load = clip_res.ok;
            end
         end
         ST_SCAN: begin
            shift_en = out_free;
            hold_load = out_free && expire && clip_res.ok;
            out_load = hold_load && hold_valid_ff;
         end
         ST_FINISH: begin
            out_load = out_free && hold_valid_ff;
            out_last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (hold_load) begin
            hold_valid_ff <= 1'b1;
         end else if (out_load && out_last) begin
            hold_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= out_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_chan.data;
      end
      if (state_ff == ST_DECODE) begin
         scan_cnt_ff <= '0;
      end else if (shift_en) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end
      if (hold_load) begin
         hold_ff <= clip_res;
      end
      if (out_load) begin
         rsp_ff.erase_x <= hold_ff.x;
         rsp_ff.erase_y <= hold_ff.y;
         rsp_ff.erase_w <= hold_ff.w;
         rsp_ff.erase_h <= hold_ff.h;
         rsp_ff.last <= out_last;
      end
   end

endmodule

/* sim/tb_timed_rect_erase_scheduler.sv */
`timescale 1ns / 100ps

module tb_timed_rect_erase_scheduler;
   import tres_pkg::*;

   // The block is built with eight pending slots, the same count the predictor keeps.
   localparam int SLOTS = 8;

   // The slowest correct run is about 260 requests. Each one can meet up to eight
   // responses behind the longest stalls and the longest sender gap, so the limit
   // below leaves plenty of room.
   localparam int LIMIT_CYCLES = 400000;
   localparam int PLAN_ROWS = 21;
   localparam int NUM_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 34;

   // Directed rows either carry a typed-in expectation or defer to the predictor.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NONE,
      ROW_ONE
   } check_type;

   typedef struct {
      req_type item;
      check_type check;
      rsp_type erase;
   } plan_row_type;

   typedef struct {
      logic [DWELL_W-1:0] max_dwell;
      logic [PERIOD_W-1:0] period;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic live;
      bit idle;
   } phase_row_type;

   localparam rsp_type NO_ERASE = '0;

   logic clock;
   logic reset;

   tres_chan_if #(.payload_type(req_type)) req_if ();
   tres_chan_if #(.payload_type(rsp_type)) rsp_if ();
   tres_chan_if #(.payload_type(csr_type)) csr_if ();

   timed_rect_erase_scheduler #(
      .PENDING_SLOTS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   // Predictor state: a private copy of the configuration and of the pending slots.
   logic [DWELL_W-1:0] cfg_max_dwell;
   logic [PERIOD_W-1:0] cfg_period;
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   logic cfg_live;

   bit pend_used [SLOTS];
   int pend_x [SLOTS];
   int pend_y [SLOTS];
   int pend_w [SLOTS];
   int pend_h [SLOTS];
   logic [DWELL_W-1:0] pend_left [SLOTS];

   // These are the erases still owed by the block, oldest first.
   rsp_type erase_queue[$];

   int error_count;
   int queue_mark;
   int rsp_hold;
   int cycle_count;
   bit idle_on;
   check_type row_check;
   rsp_type row_erase;

   plan_row_type plan [PLAN_ROWS];
   phase_row_type phases [NUM_PHASES];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The surface is saturated to the largest supported size before any clipping.
   function automatic int surf_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_SURFACE_DIM) ? int'(MAX_SURFACE_DIM) : int'(v);
   endfunction

   // This clips one rectangle to the live surface and queues it unless the clip is empty.
   function automatic void clip_and_queue(input int x, input int y, input int w, input int h);
      int sw;
      int sh;
      rsp_type e;
      sw = surf_dim(cfg_width);
      sh = surf_dim(cfg_height);
      if (!cfg_live || w <= 0 || h <= 0) return;
      if (x < 0) begin
         w += x;
         x = 0;
      end
      if (y < 0) begin
         h += y;
         y = 0;
      end
      if (x >= sw || y >= sh) return;
      if (x + w > sw) w = sw - x;
      if (y + h > sh) h = sh - y;
      if (w <= 0 || h <= 0) return;
      e.erase_x = x[POS_W-1:0];
      e.erase_y = y[POS_W-1:0];
      e.erase_w = w[LEN_W-1:0];
      e.erase_h = h[LEN_W-1:0];
      e.last = 1'b0;
      erase_queue.push_back(e);
   endfunction

   // This works out every erase that one accepted request causes, in the order the block
   // emits them. The final one carries the last flag.
   function automatic void predict_erases(input req_type r);
      int depth;
      int i;
      logic [DWELL_W-1:0] ms;
      bit stored;
      rsp_type tail;
      depth = erase_queue.size();
      if (r.command == CMD_ERASE) begin
         ms = r.dwell_ms;
         stored = 1'b0;
         if (ms != '0) begin
            if (ms > cfg_max_dwell) ms = cfg_max_dwell;
            for (i = 0; i < SLOTS && !stored; i++) begin
               if (!pend_used[i]) begin
                  pend_x[i] = $signed(r.rect_x);
                  pend_y[i] = $signed(r.rect_y);
                  pend_w[i] = $signed(r.rect_w);
                  pend_h[i] = $signed(r.rect_h);
                  pend_left[i] = ms;
                  pend_used[i] = 1'b1;
                  stored = 1'b1;
               end
            end
         end
         if (!stored) begin
            clip_and_queue($signed(r.rect_x), $signed(r.rect_y),
                           $signed(r.rect_w), $signed(r.rect_h));
         end
      end else if (cfg_live) begin
         // A dead surface makes a tick a no-op, so panic is only honored while live.
         if (r.panic) begin
            for (i = 0; i < SLOTS; i++) pend_used[i] = 1'b0;
            clip_and_queue(0, 0, surf_dim(cfg_width), surf_dim(cfg_height));
         end
         for (i = 0; i < SLOTS; i++) begin
            if (pend_used[i]) begin
               if (pend_left[i] > cfg_period) begin
                  pend_left[i] = pend_left[i] - cfg_period;
               end else begin
                  clip_and_queue(pend_x[i], pend_y[i], pend_w[i], pend_h[i]);
                  pend_used[i] = 1'b0;
               end
            end
         end
      end
      if (erase_queue.size() > depth) begin
         tail = erase_queue.pop_back();
         tail.last = 1'b1;
         erase_queue.push_back(tail);
      end
   endfunction

   function automatic void apply_setting(input csr_type c);
      case (c.reg_index)
         CSR_MAX_DWELL: cfg_max_dwell = c.reg_data;
         CSR_TICK_PERIOD: cfg_period = c.reg_data[PERIOD_W-1:0];
         CSR_SURF_WIDTH: cfg_width = c.reg_data[DIM_W-1:0];
         CSR_SURF_HEIGHT: cfg_height = c.reg_data[DIM_W-1:0];
         CSR_SURF_LIVE: cfg_live = c.reg_data[0];
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_erase(input rsp_type got);
      rsp_type want;
      if (erase_queue.size() == 0) begin
         $error("erase response with none outstanding: x=%0d y=%0d w=%0d h=%0d last=%0b",
                got.erase_x, got.erase_y, got.erase_w, got.erase_h, got.last);
         error_count++;
         return;
      end
      want = erase_queue.pop_front();
      compare_field("erase_x", want.erase_x, got.erase_x);
      compare_field("erase_y", want.erase_y, got.erase_y);
      compare_field("erase_w", want.erase_w, got.erase_w);
      compare_field("erase_h", want.erase_h, got.erase_h);
      compare_field("last", want.last, got.last);
   endfunction

   // Most gaps are zero or short. Now and then one runs long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Coordinates mostly land around the surface. A fifth of them are raw 16-bit values,
   // so that every bit gets toggled.
   function automatic logic [COORD_W-1:0] rand_coord(input int span);
      if ($urandom_range(0, 4) == 0) return COORD_W'($urandom);
      return COORD_W'($urandom_range(0, span + 200) - 100);
   endfunction

   function automatic logic [COORD_W-1:0] rand_len(input int span);
      if ($urandom_range(0, 4) == 0) return COORD_W'($urandom);
      return COORD_W'($urandom_range(0, span / 2 + 40) - 20);
   endfunction

   // A dwell of a few tick periods makes slots expire within a handful of ticks.
   // Zero, full-scale and raw values are mixed in with those.
   function automatic logic [DWELL_W-1:0] rand_dwell();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return '0;
      if (pick < 70) return DWELL_W'($urandom_range(1, 4 * cfg_period + 1));
      if (pick < 80) return {DWELL_W{1'b1}};
      return DWELL_W'($urandom);
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.command = ($urandom_range(0, 99) < 55) ? CMD_ERASE : CMD_TICK;
      r.rect_x = rand_coord(surf_dim(cfg_width));
      r.rect_y = rand_coord(surf_dim(cfg_height));
      r.rect_w = rand_len(surf_dim(cfg_width));
      r.rect_h = rand_len(surf_dim(cfg_height));
      r.dwell_ms = rand_dwell();
      r.panic = ($urandom_range(0, 99) < 7);
      return r;
   endfunction

   function automatic req_type make_erase(input int x, input int y, input int w, input int h,
                                          input int dwell, input bit panic);
      req_type r;
      r.command = CMD_ERASE;
      r.rect_x = x[COORD_W-1:0];
      r.rect_y = y[COORD_W-1:0];
      r.rect_w = w[COORD_W-1:0];
      r.rect_h = h[COORD_W-1:0];
      r.dwell_ms = dwell[DWELL_W-1:0];
      r.panic = panic;
      return r;
   endfunction

   // A tick carries junk in its unused fields. The block has to ignore it.
   function automatic req_type make_tick(input bit panic);
      req_type r;
      r.command = CMD_TICK;
      r.rect_x = 16'sh8000;
      r.rect_y = 16'sh7fff;
      r.rect_w = -16'sd1;
      r.rect_h = 16'sh8000;
      r.dwell_ms = {DWELL_W{1'b1}};
      r.panic = panic;
      return r;
   endfunction

   function automatic rsp_type erase_of(input int x, input int y, input int w, input int h);
      rsp_type e;
      e.erase_x = x[POS_W-1:0];
      e.erase_y = y[POS_W-1:0];
      e.erase_w = w[LEN_W-1:0];
      e.erase_h = h[LEN_W-1:0];
      e.last = 1'b1;
      return e;
   endfunction

   // The sender is entered at a rising edge and leaves at the rising edge that accepts the
   // request. Valid therefore stays high into a zero-gap follower without dropping.
   task automatic send_request(input req_type item, input check_type check,
                               input rsp_type erase);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= item;
      row_check = check;
      row_erase = erase;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // This holds requests back until every owed erase has come, then waits out any
   // tail of work that produces nothing.
   task automatic drain_erases(input int pause);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (erase_queue.size() != 0) @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [DWELL_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= '{reg_index: idx, reg_data: value};
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // The response side goes through one ready cycle, then possibly a stall. No new
   // stall is picked while idling is switched off.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (idle_on) rsp_hold = pick_gap();
      end
   end

   // Everything is sampled at the rising edge. Responses are checked before a request
   // accepted on the same edge adds its erases, so a stray response cannot pair with
   // an erase that was only just predicted.
   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) check_erase(rsp_if.data);
      if (csr_if.valid && csr_if.ready) apply_setting(csr_if.data);
      if (req_if.valid && req_if.ready) begin
         queue_mark = erase_queue.size();
         predict_erases(req_if.data);
         // On a directed row with a typed-in answer, that answer replaces the
         // predicted erases. The slot state is still advanced by the predictor.
         if (row_check != ROW_PREDICT) begin
            while (erase_queue.size() > queue_mark) void'(erase_queue.pop_back());
            if (row_check == ROW_ONE) erase_queue.push_back(row_erase);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int k;
      int n;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;
      rsp_hold = 0;
      idle_on = 1'b0;
      error_count = 0;
      row_check = ROW_PREDICT;
      row_erase = NO_ERASE;

      // These are the register values after reset, and every slot is free.
      cfg_max_dwell = 20'd10000;
      cfg_period = 16'd150;
      cfg_width = 12'd800;
      cfg_height = 12'd480;
      cfg_live = 1'b1;
      for (k = 0; k < SLOTS; k++) pend_used[k] = 1'b0;

      // The directed rows run on the 800x480 surface, with a 10000 ms clamp and a
      // 150 ms tick. First come immediate erases at the coordinate extremes and
      // partial clips.
      plan[0] = '{make_erase(0, 0, 10, 20, 0, 0), ROW_ONE, erase_of(0, 0, 10, 20)};
      plan[1] = '{make_erase(-32768, -32768, 32767, 32767, 0, 0), ROW_NONE, NO_ERASE};
      plan[2] = '{make_erase(32767, 32767, 32767, 32767, 0, 0), ROW_NONE, NO_ERASE};
      plan[3] = '{make_erase(790, 470, 100, 100, 0, 0), ROW_ONE, erase_of(790, 470, 10, 10)};
      // Panic on an erase request has no effect, and an empty size drops the erase.
      plan[4] = '{make_erase(-5, -7, 0, -32768, 0, 1), ROW_NONE, NO_ERASE};
      plan[5] = '{make_erase(-10, -3, 30, 13, 0, 0), ROW_ONE, erase_of(0, 0, 20, 10)};
      // With nothing parked, a panic tick yields the whole surface alone.
      plan[6] = '{make_tick(1), ROW_ONE, erase_of(0, 0, 800, 480)};
      // Eight parked erases fill the table. The first dwell gets clamped, and the others
      // sit just above, at and below one tick period.
      plan[7] = '{make_erase(100, 50, 40, 30, 1048575, 0), ROW_PREDICT, NO_ERASE};
      plan[8] = '{make_erase(-20, -20, 60, 60, 1, 0), ROW_PREDICT, NO_ERASE};
      plan[9] = '{make_erase(0, 0, 800, 480, 150, 0), ROW_PREDICT, NO_ERASE};
      plan[10] = '{make_erase(799, 479, 5, 5, 149, 0), ROW_PREDICT, NO_ERASE};
      plan[11] = '{make_erase(10, 10, 1, 1, 2, 0), ROW_PREDICT, NO_ERASE};
      plan[12] = '{make_erase(-32768, 0, 32767, 1, 150, 0), ROW_PREDICT, NO_ERASE};
      plan[13] = '{make_erase(400, 240, 32767, 32767, 100, 0), ROW_PREDICT, NO_ERASE};
      plan[14] = '{make_erase(0, 0, 2048, 2048, 151, 0), ROW_PREDICT, NO_ERASE};
      // The table is full now, so this erase goes out at once.
      plan[15] = '{make_erase(5, 5, 5, 5, 500, 0), ROW_PREDICT, NO_ERASE};
      // Two plain ticks expire most of the slots. A panic tick then clears the rest.
      plan[16] = '{make_tick(0), ROW_PREDICT, NO_ERASE};
      plan[17] = '{make_tick(0), ROW_PREDICT, NO_ERASE};
      plan[18] = '{make_tick(1), ROW_ONE, erase_of(0, 0, 800, 480)};
      plan[19] = '{make_tick(0), ROW_NONE, NO_ERASE};
      plan[20] = '{make_erase(0, 0, 32767, 32767, 0, 0), ROW_ONE, erase_of(0, 0, 800, 480)};

      // The random phases visit the register extremes. These include a zero clamp, a
      // surface above the maximum size, a zero period, a zero-width surface and a dead
      // surface that still parks erases, followed by a live one that flushes them.
      phases[0] = '{20'd1, 16'd1, 12'd64, 12'd64, 1'b1, 1'b1};
      phases[1] = '{20'hFFFFF, 16'hFFFF, 12'd2048, 12'd2048, 1'b1, 1'b0};
      phases[2] = '{20'd0, 16'd150, 12'd4095, 12'd3000, 1'b1, 1'b1};
      phases[3] = '{20'd500, 16'd0, 12'd0, 12'd100, 1'b1, 1'b1};
      phases[4] = '{20'd3000, 16'd200, 12'd800, 12'd600, 1'b0, 1'b1};
      phases[5] = '{20'd3000, 16'd200, 12'd800, 12'd600, 1'b1, 1'b1};
      phases[6] = '{20'd2500, 16'd120, 12'd1024, 12'd768, 1'b1, 1'b1};

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_on = 1'b1;
      for (k = 0; k < PLAN_ROWS; k++) send_request(plan[k].item, plan[k].check, plan[k].erase);

      for (k = 0; k < NUM_PHASES; k++) begin
         // Register writes are only made once the block has gone quiet.
         drain_erases(20);
         write_setting(CSR_MAX_DWELL, phases[k].max_dwell);
         write_setting(CSR_TICK_PERIOD, DWELL_W'(phases[k].period));
         write_setting(CSR_SURF_WIDTH, DWELL_W'(phases[k].width));
         write_setting(CSR_SURF_HEIGHT, DWELL_W'(phases[k].height));
         write_setting(CSR_SURF_LIVE, DWELL_W'(phases[k].live));
         idle_on = phases[k].idle;
         @(posedge clock);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Partway through each phase, the sender holds off until every
            // owed erase has arrived.
            if (n == ITEMS_PER_PHASE / 2) drain_erases(0);
            send_request(random_request(), ROW_PREDICT, NO_ERASE);
         end
      end

      drain_erases(30);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
